// File: design/gqs_pkg.sv
package gqs_pkg;

    localparam int QW = 16;
    localparam logic signed [QW-1:0] Q_ONE = 16'sd16384;
    localparam logic [16:0] W_ONE = 17'd65536;

    // configuration register indexes
    localparam logic [1:0] REG_BLEND_WEIGHT    = 2'd0;
    localparam logic [1:0] REG_STILL_THRESHOLD = 2'd1;

    typedef logic signed [QW-1:0] gqs_comp_t;
    typedef gqs_comp_t [3:0] gqs_quat_t;   // [0]=w [1]=x [2]=y [3]=z

    typedef struct packed {
        logic      channel;
        gqs_comp_t quat_w;
        gqs_comp_t quat_x;
        gqs_comp_t quat_y;
        gqs_comp_t quat_z;
        gqs_comp_t rate_x;
        gqs_comp_t rate_y;
        gqs_comp_t rate_z;
        gqs_comp_t accel_x;
        gqs_comp_t accel_y;
        gqs_comp_t accel_z;
    } gqs_sample_t;

    typedef struct packed {
        logic      out_channel;
        gqs_comp_t smooth_w;
        gqs_comp_t smooth_x;
        gqs_comp_t smooth_y;
        gqs_comp_t smooth_z;
        gqs_comp_t out_rate_x;
        gqs_comp_t out_rate_y;
        gqs_comp_t out_rate_z;
        gqs_comp_t out_accel_x;
        gqs_comp_t out_accel_y;
        gqs_comp_t out_accel_z;
        logic      is_still;
    } gqs_result_t;

    // control between the top level and the arithmetic engine
    typedef struct packed {
        logic start;
        logic ack;
    } gqs_ctrl_t;

endpackage

// File: design/gqs_engine.sv
module gqs_engine import gqs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  gqs_ctrl_t ctrl,
    input  logic [16:0] weight,
    input  gqs_quat_t raw,
    input  gqs_quat_t prev,
    output logic      done,
    output gqs_quat_t quat
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_BLEND  = 7'b0000010,
        S_SQUARE = 7'b0000100,
        S_ROOT   = 7'b0001000,
        S_PREP   = 7'b0010000,
        S_DIVIDE = 7'b0100000,
        S_DONE   = 7'b1000000
    } eng_state_t;

    eng_state_t state_reg;
    logic [4:0] cnt_reg;
    logic [1:0] lane_reg;
    logic [16:0] wt_reg;
    logic signed [32:0] acc_reg [4];
    logic signed [32:0] mcand_reg [4];
    logic [30:0] mag_reg [4];
    logic        neg_reg [4];
    logic [30:0] sq_mq_reg;
    logic [61:0] sq_mc_reg;
    logic [63:0] sum_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [32:0] den_reg;
    logic [33:0] drem_reg [4];
    logic [14:0] dnum_reg [4];
    logic [14:0] quo_reg [4];
    logic        zero_reg;

    logic [16:0] wt_sat;
    gqs_comp_t   raw_sat [4];
    logic signed [16:0] diff [4];
    logic signed [32:0] lane_acc;
    logic [32:0] lane_abs;
    logic [35:0] root_t;
    logic [35:0] root_trial;
    logic [33:0] div_t [4];
    logic [45:0] div_num [4];

    assign wt_sat = (weight > W_ONE) ? W_ONE : weight;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (raw[i] > Q_ONE)
                raw_sat[i] = Q_ONE;
            else if (raw[i] < -Q_ONE)
                raw_sat[i] = -Q_ONE;
            else
                raw_sat[i] = raw[i];
            diff[i] = 17'(raw_sat[i]) - 17'(prev[i]);
            div_t[i] = {drem_reg[i][32:0], dnum_reg[i][14]};
            div_num[i] = {mag_reg[i], 15'b0} + {14'b0, root_reg};
        end
    end

    assign lane_acc = acc_reg[lane_reg];
    assign lane_abs = lane_acc[32] ? 33'(-lane_acc) : 33'(lane_acc);

    // one result bit per step: bring down two radicand bits
    assign root_t = {rem_reg, sum_reg[63:62]};
    assign root_trial = {2'b0, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            lane_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        state_reg <= S_BLEND;
                        cnt_reg   <= '0;
                    end
                end
                S_BLEND:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd16)
                    begin
                        state_reg <= S_SQUARE;
                        cnt_reg   <= '0;
                        lane_reg  <= '0;
                    end
                end
                S_SQUARE:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        lane_reg <= lane_reg + 2'd1;
                        if (lane_reg == 2'd3)
                            state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                        state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= (root_reg == '0) ? S_DONE : S_DIVIDE;
                end
                S_DIVIDE:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd14)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (ctrl.ack)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    wt_reg   <= wt_sat;
                    sum_reg  <= '0;
                    rem_reg  <= '0;
                    root_reg <= '0;
                    for (int i = 0; i < 4; i++)
                    begin
                        acc_reg[i]   <= {prev[i][15], prev[i], 16'b0};
                        mcand_reg[i] <= 33'(diff[i]);
                    end
                end
            end
            S_BLEND:
            begin
                // acc = s*65536 + (q - s)*a, one weight bit per cycle
                wt_reg <= wt_reg >> 1;
                for (int i = 0; i < 4; i++)
                begin
                    if (wt_reg[0])
                        acc_reg[i] <= acc_reg[i] + mcand_reg[i];
                    mcand_reg[i] <= mcand_reg[i] <<< 1;
                end
            end
            S_SQUARE:
            begin
                if (cnt_reg == 5'd0)
                begin
                    mag_reg[lane_reg] <= lane_abs[30:0];
                    neg_reg[lane_reg] <= lane_acc[32];
                    sq_mq_reg <= lane_abs[30:0];
                    sq_mc_reg <= {31'b0, lane_abs[30:0]};
                end
                else
                begin
                    if (sq_mq_reg[0])
                        sum_reg <= sum_reg + {2'b0, sq_mc_reg};
                    sq_mq_reg <= sq_mq_reg >> 1;
                    sq_mc_reg <= sq_mc_reg << 1;
                end
            end
            S_ROOT:
            begin
                sum_reg <= sum_reg << 2;
                if (root_t >= root_trial)
                begin
                    rem_reg  <= 34'(root_t - root_trial);
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= root_t[33:0];
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            S_PREP:
            begin
                zero_reg <= (root_reg == '0);
                den_reg  <= {root_reg, 1'b0};
                // rounded quotient: (m*2^15 + norm) / (2*norm)
                for (int i = 0; i < 4; i++)
                begin
                    drem_reg[i] <= {3'b0, div_num[i][45:15]};
                    dnum_reg[i] <= div_num[i][14:0];
                    quo_reg[i]  <= '0;
                end
            end
            S_DIVIDE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    dnum_reg[i] <= dnum_reg[i] << 1;
                    if (div_t[i] >= {1'b0, den_reg})
                    begin
                        drem_reg[i] <= div_t[i] - {1'b0, den_reg};
                        quo_reg[i]  <= {quo_reg[i][13:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg[i] <= div_t[i];
                        quo_reg[i]  <= {quo_reg[i][13:0], 1'b0};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done = (state_reg == S_DONE);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (zero_reg)
                quat[i] = (i == 0) ? Q_ONE : '0;
            else if (neg_reg[i])
                quat[i] = -gqs_comp_t'({1'b0, quo_reg[i]});
            else
                quat[i] = gqs_comp_t'({1'b0, quo_reg[i]});
        end
    end

endmodule

// File: design/gated_quaternion_smoother.sv
// Quaternion smoother for IMU samples, one smoothed orientation per sensor
// channel. A sample whose three gyro magnitudes are all below still_threshold
// holds the channel's state and is returned through the sample and output
// registers. Any other sample blends by blend_weight and renormalizes
// through a bit-serial engine: shift-add blending (4 lanes), serial squaring
// of the four lanes into one accumulator, square root, a setup step and
// division (4 lanes). One sample is in work at a time; a finished result
// sits in the output register while the next request is taken.
module gated_quaternion_smoother import gqs_pkg::*; #(
    parameter int CHANNELS = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  gqs_sample_t sample,
    output logic        result_valid,
    input  logic        result_stall,
    output gqs_result_t result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [16:0] blend_weight_reg;
    logic [14:0] still_threshold_reg;
    gqs_quat_t   state_reg [CHANNELS];
    logic        busy_reg;
    logic        still_reg;
    logic [ChW-1:0] ch_reg;
    gqs_sample_t item_reg;
    logic        result_valid_reg;
    gqs_result_t result_reg;

    logic        accept;
    logic        still_now;
    logic [ChW-1:0] ch_idx;
    logic        load_out;
    logic        eng_done;
    gqs_quat_t   eng_quat;
    gqs_quat_t   raw_quat;
    gqs_quat_t   new_quat;
    gqs_ctrl_t   ctrl;

    function automatic logic [15:0] mag16(input gqs_comp_t v);
        mag16 = v[15] ? 16'(-v) : 16'(v);
    endfunction

    assign cfg_ready = 1'b1;
    assign sample_stall = busy_reg;
    assign accept = sample_valid && !sample_stall;
    assign ch_idx = (CHANNELS == 1) ? '0 : ChW'(sample.channel);

    assign still_now = (mag16(sample.rate_x) < {1'b0, still_threshold_reg})
                    && (mag16(sample.rate_y) < {1'b0, still_threshold_reg})
                    && (mag16(sample.rate_z) < {1'b0, still_threshold_reg});

    assign raw_quat[0] = sample.quat_w;
    assign raw_quat[1] = sample.quat_x;
    assign raw_quat[2] = sample.quat_y;
    assign raw_quat[3] = sample.quat_z;

    assign load_out = busy_reg && (still_reg || eng_done)
                   && (!result_valid_reg || !result_stall);
    assign ctrl.start = accept && !still_now;
    assign ctrl.ack = load_out && !still_reg;

    gqs_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .weight (blend_weight_reg),
        .raw    (raw_quat),
        .prev   (state_reg[ch_idx]),
        .done   (eng_done),
        .quat   (eng_quat)
    );

    assign new_quat = still_reg ? state_reg[ch_reg] : eng_quat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_weight_reg    <= 17'd19661;
            still_threshold_reg <= 15'd123;
            busy_reg            <= 1'b0;
            result_valid_reg    <= 1'b0;
            // element [0] is w and sits in the low bits
            for (int c = 0; c < CHANNELS; c++)
                state_reg[c] <= {16'sd0, 16'sd0, 16'sd0, Q_ONE};
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_BLEND_WEIGHT:    blend_weight_reg <= cfg_data;
                    REG_STILL_THRESHOLD: still_threshold_reg <= cfg_data[14:0];
                    default:
                    begin
                    end
                endcase
            end

            if (accept)
                busy_reg <= 1'b1;
            else if (load_out)
                busy_reg <= 1'b0;

            if (load_out)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;

            if (load_out && !still_reg)
                state_reg[ch_reg] <= eng_quat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg  <= sample;
            still_reg <= still_now;
            ch_reg    <= ch_idx;
        end
        if (load_out)
        begin
            result_reg.out_channel <= item_reg.channel;
            result_reg.smooth_w    <= new_quat[0];
            result_reg.smooth_x    <= new_quat[1];
            result_reg.smooth_y    <= new_quat[2];
            result_reg.smooth_z    <= new_quat[3];
            result_reg.out_rate_x  <= item_reg.rate_x;
            result_reg.out_rate_y  <= item_reg.rate_y;
            result_reg.out_rate_z  <= item_reg.rate_z;
            result_reg.out_accel_x <= item_reg.accel_x;
            result_reg.out_accel_y <= item_reg.accel_y;
            result_reg.out_accel_z <= item_reg.accel_z;
            result_reg.is_still    <= still_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result = result_reg;

    a_ack_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ack |-> eng_done)
        else $error("engine acknowledged before it finished");

    a_done_only_moving: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(eng_done) |-> busy_reg && !still_reg)
        else $error("engine finished without a moving request in work");

    a_idle_engine: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !eng_done)
        else $error("engine holds a result with no request in work");

    a_still_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && still_now && !result_valid_reg) |=> ##1 result_valid_reg)
        else $error("still request did not reach the output");

endmodule
